/* hw/rtl/seg2d_pkg.sv */
// shared widths and payload types for the 2d segment intersection unit
package seg2d_pkg;

    localparam int COORD_BITS = 32;
    // coordinate differences carry one extra sign bit
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    // den, sn and tn: difference of two products
    localparam int CROSS_W    = PROD_W + 1;
    // magnitude of a coordinate difference
    localparam int MAG_W      = COORD_BITS;
    // tn magnitude is split in two slices for the scale multiply
    localparam int TN_LO_W    = (CROSS_W + 1) / 2;
    localparam int TN_HI_W    = CROSS_W - TN_LO_W;
    localparam int NUM_W      = CROSS_W + MAG_W;
    // quotient magnitude never exceeds the direction magnitude
    localparam int QUO_W      = COORD_BITS;
    localparam int QUO_IDX_W  = $clog2(QUO_W);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_start_x;
        logic signed [COORD_BITS-1:0] a_start_y;
        logic signed [COORD_BITS-1:0] a_end_x;
        logic signed [COORD_BITS-1:0] a_end_y;
        logic signed [COORD_BITS-1:0] b_start_x;
        logic signed [COORD_BITS-1:0] b_start_y;
        logic signed [COORD_BITS-1:0] b_end_x;
        logic signed [COORD_BITS-1:0] b_end_y;
    } t_seg_req;

    typedef struct packed {
        logic                         hit;
        logic signed [COORD_BITS-1:0] cross_x;
        logic signed [COORD_BITS-1:0] cross_y;
    } t_seg_rsp;

    // one axis of the divider: partial remainder, quotient so far, sign and base point
    typedef struct packed {
        logic [NUM_W-1:0]      rem;
        logic [QUO_W-1:0]      quo;
        logic                  neg;
        logic [COORD_BITS-1:0] base;
    } t_div_lane;

    typedef struct packed {
        logic               hit;
        logic [CROSS_W-1:0] den;
        t_div_lane          x;
        t_div_lane          y;
    } t_div_stage;

endpackage

/* hw/rtl/segment_intersection_2d_unit.sv */
// top level of the 2d segment intersection unit
//
//  channel   direction  handshake            payload
//  request   in         i_valid / o_ready    i_req  (two segments, q20.12)
//  result    out        o_valid / i_ready    o_rsp  (hit, crossing point)
//
// one request per cycle while the skid stage is empty; each result passes through
// 6 front stages (products, range test, scale multiply), 32 divider stages
// of one quotient bit each, and the output register.
// the pipeline holds as a whole once the output register and skid stage are
// both full; o_ready follows the skid stage only.
// reset clears the valid bits; data registers are not reset.
module segment_intersection_2d_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  seg2d_pkg::t_seg_req i_req,
    output logic                o_valid,
    input  logic                i_ready,
    output seg2d_pkg::t_seg_rsp o_rsp
);

    logic                  en;
    logic                  front_valid;
    seg2d_pkg::t_div_stage front_div;
    logic                  div_valid;
    seg2d_pkg::t_div_stage div_out;

    seg2d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_req   (i_req),
        .o_valid (front_valid),
        .o_div   (front_div)
    );

    seg2d_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_valid),
        .i_div   (front_div),
        .o_valid (div_valid),
        .o_div   (div_out)
    );

    seg2d_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid),
        .i_div   (div_out),
        .o_en    (en),
        .o_valid (o_valid),
        .o_rsp   (o_rsp),
        .i_ready (i_ready)
    );

    assign o_ready = en;

endmodule

/* hw/rtl/seg2d_front.sv */
// front pipeline: differences, cross products, range test and scale multiply
module seg2d_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  seg2d_pkg::t_seg_req   i_req,
    output logic                  o_valid,
    output seg2d_pkg::t_div_stage o_div
);

    // 0 <= num/den <= 1 with signs taken into account
    function automatic logic range_ok(
        input logic [seg2d_pkg::CROSS_W-1:0] num,
        input logic [seg2d_pkg::CROSS_W-1:0] den
    );
        logic [seg2d_pkg::CROSS_W-1:0] diff;
        logic                          num_neg;
        logic                          num_zero;
        logic                          diff_neg;
        logic                          diff_zero;
        diff      = den - num;
        num_neg   = num[seg2d_pkg::CROSS_W-1];
        num_zero  = (num == '0);
        diff_neg  = diff[seg2d_pkg::CROSS_W-1];
        diff_zero = (diff == '0);
        if (den[seg2d_pkg::CROSS_W-1]) begin
            return (num_neg || num_zero) && (diff_neg || diff_zero);
        end else begin
            return !num_neg && !diff_neg;
        end
    endfunction

    logic [5:0] r_valid;

    // stage 1
    logic signed [seg2d_pkg::DIFF_W-1:0]     r_dax, r_day, r_dbx, r_dby, r_ex, r_ey;
    logic        [seg2d_pkg::COORD_BITS-1:0] r_s1_ax, r_s1_ay;
    // stage 2
    logic signed [seg2d_pkg::PROD_W-1:0]     r_p_den0, r_p_den1, r_p_sn0, r_p_sn1;
    logic signed [seg2d_pkg::PROD_W-1:0]     r_p_tn0, r_p_tn1;
    logic signed [seg2d_pkg::DIFF_W-1:0]     r_s2_dax, r_s2_day;
    logic        [seg2d_pkg::COORD_BITS-1:0] r_s2_ax, r_s2_ay;
    // stage 3
    logic        [seg2d_pkg::CROSS_W-1:0]    r_den, r_sn, r_tn;
    logic signed [seg2d_pkg::DIFF_W-1:0]     r_s3_dax, r_s3_day;
    logic        [seg2d_pkg::COORD_BITS-1:0] r_s3_ax, r_s3_ay;
    // stage 4
    logic                                    r_s4_hit;
    logic        [seg2d_pkg::CROSS_W-1:0]    r_tn_mag, r_s4_den_mag;
    logic        [seg2d_pkg::MAG_W-1:0]      r_dx_mag, r_dy_mag;
    logic                                    r_s4_neg_x, r_s4_neg_y;
    logic        [seg2d_pkg::COORD_BITS-1:0] r_s4_ax, r_s4_ay;
    // stage 5
    logic [seg2d_pkg::TN_LO_W+seg2d_pkg::MAG_W-1:0] r_px_lo, r_py_lo;
    logic [seg2d_pkg::TN_HI_W+seg2d_pkg::MAG_W-1:0] r_px_hi, r_py_hi;
    logic                                    r_s5_hit;
    logic        [seg2d_pkg::CROSS_W-1:0]    r_s5_den_mag;
    logic                                    r_s5_neg_x, r_s5_neg_y;
    logic        [seg2d_pkg::COORD_BITS-1:0] r_s5_ax, r_s5_ay;
    // stage 6
    seg2d_pkg::t_div_stage                   r_div;

    logic                                    den_neg;
    logic                                    tn_neg;
    logic        [seg2d_pkg::CROSS_W-1:0]    tn_abs, den_abs;
    logic        [seg2d_pkg::DIFF_W-1:0]     dax_abs, day_abs;
    logic                                    hit;

    always_comb begin
        den_neg = r_den[seg2d_pkg::CROSS_W-1];
        tn_neg  = r_tn[seg2d_pkg::CROSS_W-1];
        tn_abs  = tn_neg ? -r_tn : r_tn;
        den_abs = den_neg ? -r_den : r_den;
        dax_abs = r_s3_dax[seg2d_pkg::DIFF_W-1] ? -r_s3_dax : r_s3_dax;
        day_abs = r_s3_day[seg2d_pkg::DIFF_W-1] ? -r_s3_day : r_s3_day;
        hit     = (r_den != '0) && range_ok(r_sn, r_den) && range_ok(r_tn, r_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dax   <= {i_req.a_end_x[seg2d_pkg::COORD_BITS-1], i_req.a_end_x}
                     - {i_req.a_start_x[seg2d_pkg::COORD_BITS-1], i_req.a_start_x};
            r_day   <= {i_req.a_end_y[seg2d_pkg::COORD_BITS-1], i_req.a_end_y}
                     - {i_req.a_start_y[seg2d_pkg::COORD_BITS-1], i_req.a_start_y};
            r_dbx   <= {i_req.b_end_x[seg2d_pkg::COORD_BITS-1], i_req.b_end_x}
                     - {i_req.b_start_x[seg2d_pkg::COORD_BITS-1], i_req.b_start_x};
            r_dby   <= {i_req.b_end_y[seg2d_pkg::COORD_BITS-1], i_req.b_end_y}
                     - {i_req.b_start_y[seg2d_pkg::COORD_BITS-1], i_req.b_start_y};
            r_ex    <= {i_req.a_start_x[seg2d_pkg::COORD_BITS-1], i_req.a_start_x}
                     - {i_req.b_start_x[seg2d_pkg::COORD_BITS-1], i_req.b_start_x};
            r_ey    <= {i_req.a_start_y[seg2d_pkg::COORD_BITS-1], i_req.a_start_y}
                     - {i_req.b_start_y[seg2d_pkg::COORD_BITS-1], i_req.b_start_y};
            r_s1_ax <= i_req.a_start_x;
            r_s1_ay <= i_req.a_start_y;

            r_p_den0 <= r_dax * r_dby;
            r_p_den1 <= r_dbx * r_day;
            r_p_sn0  <= r_dax * r_ey;
            r_p_sn1  <= r_day * r_ex;
            r_p_tn0  <= r_dbx * r_ey;
            r_p_tn1  <= r_dby * r_ex;
            r_s2_dax <= r_dax;
            r_s2_day <= r_day;
            r_s2_ax  <= r_s1_ax;
            r_s2_ay  <= r_s1_ay;

            r_den    <= {r_p_den0[seg2d_pkg::PROD_W-1], r_p_den0}
                      - {r_p_den1[seg2d_pkg::PROD_W-1], r_p_den1};
            r_sn     <= {r_p_sn0[seg2d_pkg::PROD_W-1], r_p_sn0}
                      - {r_p_sn1[seg2d_pkg::PROD_W-1], r_p_sn1};
            r_tn     <= {r_p_tn0[seg2d_pkg::PROD_W-1], r_p_tn0}
                      - {r_p_tn1[seg2d_pkg::PROD_W-1], r_p_tn1};
            r_s3_dax <= r_s2_dax;
            r_s3_day <= r_s2_day;
            r_s3_ax  <= r_s2_ax;
            r_s3_ay  <= r_s2_ay;

            r_s4_hit     <= hit;
            r_tn_mag     <= tn_abs;
            r_s4_den_mag <= den_abs;
            r_dx_mag     <= dax_abs[seg2d_pkg::MAG_W-1:0];
            r_dy_mag     <= day_abs[seg2d_pkg::MAG_W-1:0];
            r_s4_neg_x   <= tn_neg ^ den_neg ^ r_s3_dax[seg2d_pkg::DIFF_W-1];
            r_s4_neg_y   <= tn_neg ^ den_neg ^ r_s3_day[seg2d_pkg::DIFF_W-1];
            r_s4_ax      <= r_s3_ax;
            r_s4_ay      <= r_s3_ay;

            r_px_lo      <= r_tn_mag[seg2d_pkg::TN_LO_W-1:0] * r_dx_mag;
            r_px_hi      <= r_tn_mag[seg2d_pkg::CROSS_W-1:seg2d_pkg::TN_LO_W] * r_dx_mag;
            r_py_lo      <= r_tn_mag[seg2d_pkg::TN_LO_W-1:0] * r_dy_mag;
            r_py_hi      <= r_tn_mag[seg2d_pkg::CROSS_W-1:seg2d_pkg::TN_LO_W] * r_dy_mag;
            r_s5_hit     <= r_s4_hit;
            r_s5_den_mag <= r_s4_den_mag;
            r_s5_neg_x   <= r_s4_neg_x;
            r_s5_neg_y   <= r_s4_neg_y;
            r_s5_ax      <= r_s4_ax;
            r_s5_ay      <= r_s4_ay;

            r_div.hit    <= r_s5_hit;
            r_div.den    <= r_s5_den_mag;
            r_div.x.rem  <= ((seg2d_pkg::NUM_W)'(r_px_hi) << seg2d_pkg::TN_LO_W)
                          + (seg2d_pkg::NUM_W)'(r_px_lo);
            r_div.x.quo  <= '0;
            r_div.x.neg  <= r_s5_neg_x;
            r_div.x.base <= r_s5_ax;
            r_div.y.rem  <= ((seg2d_pkg::NUM_W)'(r_py_hi) << seg2d_pkg::TN_LO_W)
                          + (seg2d_pkg::NUM_W)'(r_py_lo);
            r_div.y.quo  <= '0;
            r_div.y.neg  <= r_s5_neg_y;
            r_div.y.base <= r_s5_ay;
        end
    end

    assign o_valid = r_valid[5];
    assign o_div   = r_div;

endmodule

/* hw/rtl/seg2d_div.sv */
// pipelined restoring divider, one quotient bit per stage for both axes
module seg2d_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  seg2d_pkg::t_div_stage i_div,
    output logic                  o_valid,
    output seg2d_pkg::t_div_stage o_div
);

    function automatic seg2d_pkg::t_div_lane lane_step(
        input seg2d_pkg::t_div_lane                l,
        input logic [seg2d_pkg::CROSS_W-1:0]       den,
        input logic [seg2d_pkg::QUO_IDX_W-1:0]     sh
    );
        seg2d_pkg::t_div_lane          r;
        logic [seg2d_pkg::NUM_W:0]     diff;
        r    = l;
        diff = {1'b0, l.rem} - ({1'b0, (seg2d_pkg::NUM_W)'(den)} << sh);
        if (!diff[seg2d_pkg::NUM_W]) begin
            r.rem     = diff[seg2d_pkg::NUM_W-1:0];
            r.quo[sh] = 1'b1;
        end
        return r;
    endfunction

    seg2d_pkg::t_div_stage              r_stage [seg2d_pkg::QUO_W];
    logic [seg2d_pkg::QUO_W-1:0]        r_valid;

    for (genvar k = 0; k < seg2d_pkg::QUO_W; k++) begin : g_step
        localparam logic [seg2d_pkg::QUO_IDX_W-1:0] BitIdx =
            (seg2d_pkg::QUO_IDX_W)'(seg2d_pkg::QUO_W - 1 - k);

        seg2d_pkg::t_div_stage stage_in;
        logic                  valid_in;

        if (k == 0) begin : g_first
            assign stage_in = i_div;
            assign valid_in = i_valid;
        end else begin : g_next
            assign stage_in = r_stage[k-1];
            assign valid_in = r_valid[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stage[k].hit <= stage_in.hit;
                r_stage[k].den <= stage_in.den;
                r_stage[k].x   <= lane_step(stage_in.x, stage_in.den, BitIdx);
                r_stage[k].y   <= lane_step(stage_in.y, stage_in.den, BitIdx);
            end
        end
    end

    assign o_valid = r_valid[seg2d_pkg::QUO_W-1];
    assign o_div   = r_stage[seg2d_pkg::QUO_W-1];

endmodule

/* hw/rtl/seg2d_out.sv */
// final point add, output register and skid stage that drives the pipeline enable
module seg2d_out (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  seg2d_pkg::t_div_stage i_div,
    output logic                  o_en,
    output logic                  o_valid,
    output seg2d_pkg::t_seg_rsp   o_rsp,
    input  logic                  i_ready
);

    logic                                r_out_valid, n_out_valid;
    logic                                r_skid_valid, n_skid_valid;
    seg2d_pkg::t_seg_rsp                 r_out, n_out;
    seg2d_pkg::t_seg_rsp                 r_skid, n_skid;
    seg2d_pkg::t_seg_rsp                 rsp;
    logic [seg2d_pkg::QUO_W-1:0]         off_x, off_y;
    logic                                take_new;

    always_comb begin
        off_x = i_div.x.neg ? -i_div.x.quo : i_div.x.quo;
        off_y = i_div.y.neg ? -i_div.y.quo : i_div.y.quo;
        rsp.hit     = i_div.hit;
        rsp.cross_x = i_div.hit ? i_div.x.base + off_x : '0;
        rsp.cross_y = i_div.hit ? i_div.y.base + off_y : '0;
    end

    // pipeline advances only while the skid stage is empty
    assign o_en     = !r_skid_valid;
    assign take_new = o_en && i_valid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        priority if (r_out_valid && !i_ready) begin
            if (take_new) begin
                n_skid_valid = 1'b1;
                n_skid       = rsp;
            end
        end else if (r_skid_valid) begin
            n_out_valid  = 1'b1;
            n_out        = r_skid;
            n_skid_valid = 1'b0;
        end else begin
            n_out_valid = take_new;
            n_out       = rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

endmodule

/* hw/rtl/seg2d_checker.sv */
// port-level checks for the 2d segment intersection unit, bound to the top level
module seg2d_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input seg2d_pkg::t_seg_rsp o_rsp
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rsp))
        else $error("result changed while stalled");

    // no crossing means a zero point
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_rsp.hit |-> o_rsp.cross_x == '0 && o_rsp.cross_y == '0)
        else $error("nonzero point without hit");

    // skid full implies the output register is full
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("request side blocked with empty output");

    // a taken result frees the skid stage at once
    a_ready_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready && o_valid && i_ready |=> o_ready)
        else $error("request side stays blocked after result taken");

    // nothing shows right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("output valid after reset");

endmodule

bind segment_intersection_2d_unit seg2d_checker u_checker (.*);
